FILE: rtl/mdc_pkg.sv
// shared constants, types and codes of the double-centering block
// no dependencies; imported by the interfaces, the divider, the top level and the checker
package mdc_pkg;

  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int SIZE_W   = 5;
  localparam int VAL_W    = 32;
  localparam int ROW_W    = VAL_W + IDX_W;
  localparam int TOT_W    = VAL_W + ADDR_W;
  localparam int NN_W     = $clog2(DEPTH + 1);
  // n*n*h, n*row, n*col and total summed, plus headroom for the sign
  localparam int NUM_W    = VAL_W + ADDR_W + 3;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } mdc_op_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [NN_W-1:0]   divisor;
  } mdc_div_req_t;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quotient;
  } mdc_div_rsp_t;

endpackage

FILE: rtl/mdc_in_if.sv
// input item channel: valid/ready handshake with the load or read command
// depends on mdc_pkg
interface mdc_in_if import mdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (output valid, output opcode, output row_index, output col_index,
                  output element_value, input ready);
  modport sink   (input valid, input opcode, input row_index, input col_index,
                  input element_value, output ready);
endinterface

FILE: rtl/mdc_out_if.sv
// result channel: valid/ready handshake carrying the centered element
// depends on mdc_pkg
interface mdc_out_if import mdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] centered_value;

  modport source (output valid, output centered_value, input ready);
  modport sink   (input valid, input centered_value, output ready);
endinterface

FILE: rtl/mdc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on mdc_pkg for widths and the request/response structs
module mdc_div import mdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mdc_div_req_t req,
  output mdc_div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [NN_W-1:0]  rem;
  logic [NN_W-1:0]  divisor;

  logic [NN_W:0]    rem_sh;
  logic             ge;
  logic [NN_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, quo[NUM_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        quo     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        cnt     <= CNT_W'(NUM_W);
      end else if (busy) begin
        rem <= ge ? rem_sub[NN_W-1:0] : rem_sh[NN_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/matrix_double_centering.sv
// double centering of a square matrix block held in an on-chip memory
// depends on mdc_pkg, mdc_in_if, mdc_out_if and mdc_div
//
// usage:
//   req carries one command per transfer. a load (opcode 0) writes one
//   element and updates the row sum, column sum and grand total by the
//   change in value; it gives no result. a read (opcode 1) gives one result
//   on rsp: the element minus its row mean and column mean plus the grand
//   mean, rounded to nearest and saturated to 32 bits.
//   cfg_wr_en/cfg_wr_data write the block size n (0 acts as 1, above 16 as
//   16) and clear the matrix and all sums; write only while idle.
// sequence:
//   a load reads the memory at the transfer, then writes back the value and
//   sums in S_LOAD; a load outside the block is dropped.
//   a read reads the memory at the transfer, then passes three stages of
//   multiply and add, a rounding stage, a divider start and the bit-serial
//   divider by n*n; the output register then loads once it is free. one
//   command is in flight at a time; a read outside the block gives 0
//   through the output register once it is free.
// reset and stall:
//   rst clears the matrix (per-entry valid bits), the sums and sets n to 16.
//   results sit in an output register; a new command is taken while it
//   waits, and a second read result holds the block until rsp drains.
module matrix_double_centering import mdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  mdc_in_if.sink            req,
  mdc_out_if.source         rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_SUM1,
    S_SUM2,
    S_ABS,
    S_DSTART,
    S_DIV
  } state_t;

  state_t state;
  logic   sat_state;

  // matrix memory, one read and one write port
  logic [VAL_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  vbits;
  logic [VAL_W-1:0]  rd_data;
  logic              rd_vld;

  logic signed [ROW_W-1:0] row_sums [MAX_SIZE];
  logic signed [ROW_W-1:0] col_sums [MAX_SIZE];
  logic signed [TOT_W-1:0] total;

  logic [SIZE_W-1:0] n_reg;
  logic [NN_W-1:0]   nn_reg;
  logic [SIZE_W-1:0] n_eff;
  logic [2*SIZE_W-1:0] nn_full;

  logic                    accept;
  logic                    inside_in;
  logic [ADDR_W-1:0]       addr_in;
  logic [IDX_W-1:0]        r_q;
  logic [IDX_W-1:0]        c_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    inside_q;

  logic signed [VAL_W-1:0] old_s;
  logic signed [VAL_W:0]   diff;
  logic                    load_we;

  logic signed [NUM_W-1:0] p1, p2, p3, s1, s2, num;
  logic signed [NUM_W-1:0] half;
  logic [NUM_W-1:0]        mag;
  logic                    neg;

  logic signed [NUM_W:0]   res_s;
  logic signed [VAL_W-1:0] res_sat;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_free;
  logic                    out_load;

  mdc_div_req_t div_req;
  mdc_div_rsp_t div_rsp;

  mdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    n_eff = cfg_wr_data;
    if (cfg_wr_data == '0) n_eff = SIZE_W'(1);
    if (cfg_wr_data > SIZE_W'(MAX_SIZE)) n_eff = SIZE_W'(MAX_SIZE);
    nn_full = n_eff * n_eff;
  end

  assign accept    = req.valid && req.ready;
  assign addr_in   = {req.row_index, req.col_index};
  assign inside_in = ({1'b0, req.row_index} < n_reg) && ({1'b0, req.col_index} < n_reg);
  assign req.ready = (state == S_IDLE) && !sat_state;

  assign old_s   = rd_vld ? $signed(rd_data) : '0;
  assign diff    = val_q - old_s;
  assign load_we = (state == S_LOAD);

  assign half = $signed({{(NUM_W-NN_W){1'b0}}, nn_reg >> 1});

  assign div_req.start    = (state == S_DSTART);
  assign div_req.dividend = mag;
  assign div_req.divisor  = nn_reg;

  assign out_free = !out_valid || rsp.ready;
  assign out_load = (state == S_IDLE) && sat_state && out_free;

  always_comb begin
    res_s = neg ? -$signed({1'b0, div_rsp.quotient}) : $signed({1'b0, div_rsp.quotient});
    if (!inside_q)
      res_sat = '0;
    else if (res_s > SAT_MAX)
      res_sat = SAT_MAX;
    else if (res_s < SAT_MIN)
      res_sat = SAT_MIN;
    else
      res_sat = res_s[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[{r_q, c_q}] <= val_q;
    end
    rd_data <= mem[addr_in];
    rd_vld  <= vbits[addr_in];
  end

  // valid bits stand in for a cleared memory
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      vbits <= '0;
    end else if (load_we) begin
      vbits[{r_q, c_q}] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg  <= SIZE_W'(MAX_SIZE);
      nn_reg <= NN_W'(DEPTH);
    end else if (cfg_wr_en) begin
      n_reg  <= n_eff;
      nn_reg <= nn_full[NN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      for (int i = 0; i < MAX_SIZE; i++) begin
        row_sums[i] <= '0;
        col_sums[i] <= '0;
      end
      total <= '0;
    end else if (load_we) begin
      row_sums[r_q] <= row_sums[r_q] + diff;
      col_sums[c_q] <= col_sums[c_q] + diff;
      total         <= total + diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sat_state <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_value <= res_sat;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sat_state) begin
            if (out_free) sat_state <= 1'b0;
          end else if (accept) begin
            r_q      <= req.row_index;
            c_q      <= req.col_index;
            val_q    <= req.element_value;
            inside_q <= inside_in;
            if (req.opcode == OP_LOAD) begin
              if (inside_in) state <= S_LOAD;
            end else if (inside_in) begin
              state <= S_MUL;
            end else begin
              sat_state <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_MUL: begin
          p1    <= $signed(rd_vld ? rd_data : '0) * $signed({1'b0, nn_reg});
          p2    <= row_sums[r_q] * $signed({1'b0, n_reg});
          p3    <= col_sums[c_q] * $signed({1'b0, n_reg});
          state <= S_SUM1;
        end
        S_SUM1: begin
          s1    <= p1 - p2;
          s2    <= total - p3;
          state <= S_SUM2;
        end
        S_SUM2: begin
          num   <= s1 + s2;
          state <= S_ABS;
        end
        S_ABS: begin
          // magnitude with the rounding offset folded in
          neg   <= num[NUM_W-1];
          mag   <= num[NUM_W-1] ? NUM_W'(half - num) : NUM_W'(num + half);
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state     <= S_IDLE;
            sat_state <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.centered_value = out_value;

endmodule

FILE: rtl/mdc_chk.sv
// port-level checks of the double-centering block, bound to the top level
// depends on mdc_pkg for the command codes
module mdc_chk import mdc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_opcode,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [VAL_W-1:0] rsp_value
);

  logic [1:0] pend;
  logic       rd_acc;
  logic       rsp_xfer;

  assign rd_acc   = req_valid && req_ready && (req_opcode == OP_READ);
  assign rsp_xfer = rsp_valid && rsp_ready;

  // reads accepted whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, rd_acc} - {1'b0, rsp_xfer};
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("stalled result changed");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rd_acc |=> !req_ready)
    else $error("command taken while a read is in progress");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 2'd0)
    else $error("result without an outstanding read");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    rd_acc |-> pend == 2'd0 || pend == 2'd1)
    else $error("read taken with two results outstanding");

endmodule

bind matrix_double_centering mdc_chk u_mdc_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_opcode (req.opcode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.centered_value)
);

FILE: sim/tb.sv
// testbench for matrix_double_centering: random load/read traffic checked against a scoreboard
// depends on mdc_pkg, mdc_in_if, mdc_out_if and the rtl of the block
`timescale 1ns / 100ps

module tb;
  import mdc_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  // tracks the matrix, its sums and the centered values still owed by the block
  class centering_scoreboard;
    logic [SIZE_W-1:0]       size_reg;
    logic signed [VAL_W-1:0] cells [DEPTH];
    longint                  row_total [MAX_SIZE];
    longint                  col_total [MAX_SIZE];
    longint                  grand;
    logic signed [VAL_W-1:0] expected_centered [$];

    function new();
      size_reg = SIZE_W'(MAX_SIZE);
      clear();
    endfunction

    function void clear();
      foreach (cells[i]) cells[i] = '0;
      foreach (row_total[i]) begin
        row_total[i] = 0;
        col_total[i] = 0;
      end
      grand = 0;
    endfunction

    function int size_in_use();
      int n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
      clear();
    endfunction

    function int pending();
      return expected_centered.size();
    endfunction

    function void note_command(mdc_op_t op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                               logic signed [VAL_W-1:0] v);
      longint n, nn, h, num, mag, q, res, diff;
      int     a;
      n = size_in_use();
      a = r * MAX_SIZE + c;
      if (op == OP_LOAD) begin
        if (r < n && c < n) begin
          diff = longint'(v) - longint'(cells[a]);
          cells[a] = v;
          row_total[r] += diff;
          col_total[c] += diff;
          grand += diff;
        end
      end else begin
        res = 0;
        if (r < n && c < n) begin
          nn = n * n;
          h = longint'(cells[a]);
          num = nn * h - n * row_total[r] - n * col_total[c] + grand;
          mag = (num < 0) ? -num : num;
          // round to nearest, ties away from zero
          q = (mag + nn / 2) / nn;
          res = (num < 0) ? -q : q;
          if (res > longint'(SAT_MAX)) res = longint'(SAT_MAX);
          if (res < longint'(SAT_MIN)) res = longint'(SAT_MIN);
        end
        expected_centered.push_back(VAL_W'(res));
      end
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_centered(logic signed [VAL_W-1:0] got);
      logic signed [VAL_W-1:0] want;
      if (expected_centered.size() == 0)
        return $sformatf("unexpected result centered_value=%0d", got);
      want = expected_centered.pop_front();
      if (got !== want)
        return $sformatf("centered_value mismatch: got %0d, expected %0d", got, want);
      return "";
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  bit                calm;
  int                error_count;
  int                idle_cycles;

  mdc_in_if  cmd_if ();
  mdc_out_if res_if ();

  centering_scoreboard sb = new();

  matrix_double_centering i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (cmd_if.sink),
    .rsp         (res_if.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic send_command(mdc_op_t op, int r, int c, logic signed [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 2) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= op;
    cmd_if.row_index     <= IDX_W'(r);
    cmd_if.col_index     <= IDX_W'(c);
    cmd_if.element_value <= v;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_command(op, IDX_W'(r), IDX_W'(c), v);
  endtask

  task automatic random_commands(int count);
    mdc_op_t                 op;
    int                      n, r, c;
    logic signed [VAL_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      n = sb.size_in_use();
      op = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_READ;
      // mostly inside the block, now and then any index
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_SIZE - 1) : $urandom_range(0, n - 1);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_SIZE - 1) : $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0: v = SAT_MAX;
        1: v = SAT_MIN;
        2, 3: v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        default: v = $urandom;
      endcase
      send_command(op, r, c, v);
    end
    cmd_if.valid <= 1'b0;
  endtask

  // loads give no result, so wait out the block's latency after the last read drains
  task automatic drain_and_settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_size(v);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stall bursts until the calm part
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && res_if.valid && res_if.ready) begin
      msg = sb.check_centered(res_if.centered_value);
      if (msg != "") report_mismatch(msg);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SIZE_W-1:0] sz;
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    cmd_if.valid         <= 1'b0;
    cmd_if.opcode        <= OP_LOAD;
    cmd_if.row_index     <= '0;
    cmd_if.col_index     <= '0;
    cmd_if.element_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full size after reset: cleared store, extremes at the corners, overwrite
    send_command(OP_READ, 0, 0, '0);
    send_command(OP_LOAD, 0, 0, SAT_MAX);
    send_command(OP_LOAD, 15, 15, SAT_MIN);
    send_command(OP_LOAD, 0, 15, -1);
    send_command(OP_LOAD, 15, 0, 32'sh0001_0000);
    send_command(OP_READ, 0, 0, '0);
    send_command(OP_READ, 15, 15, '0);
    send_command(OP_READ, 0, 15, '0);
    send_command(OP_READ, 7, 8, '0);
    send_command(OP_LOAD, 0, 0, SAT_MIN);
    send_command(OP_READ, 0, 0, '0);
    random_commands(120);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: sz = SIZE_W'(2);
        1: sz = SIZE_W'(1);
        2: sz = SIZE_W'(0);
        3: sz = SIZE_W'(31);
        4: sz = SIZE_W'(17);
        5: sz = SIZE_W'(8);
        6: sz = SIZE_W'($urandom_range(3, 15));
        7: sz = SIZE_W'($urandom_range(0, 31));
        default: sz = SIZE_W'(16);
      endcase
      drain_and_settle();
      if (p == 8) calm = 1'b1;
      write_size(sz);
      if (p == 0) begin
        // 2x2 checkerboard of extremes drives the result to both saturation bounds
        send_command(OP_LOAD, 0, 0, SAT_MAX);
        send_command(OP_LOAD, 1, 1, SAT_MAX);
        send_command(OP_LOAD, 0, 1, SAT_MIN);
        send_command(OP_LOAD, 1, 0, SAT_MIN);
        send_command(OP_READ, 0, 0, '0);
        send_command(OP_READ, 0, 1, '0);
        send_command(OP_LOAD, 0, 0, SAT_MIN);
        send_command(OP_LOAD, 1, 1, SAT_MIN);
        send_command(OP_LOAD, 0, 1, SAT_MAX);
        send_command(OP_LOAD, 1, 0, SAT_MAX);
        send_command(OP_READ, 1, 1, '0);
        // outside the block: load ignored, read returns zero; a last read inside follows
        send_command(OP_LOAD, 2, 0, 32'sh1234_5678);
        send_command(OP_LOAD, 0, 5, 32'sh1234_5678);
        send_command(OP_READ, 3, 3, '0);
        send_command(OP_READ, 1, 0, '0);
      end
      random_commands(110);
    end
    drain_and_settle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mdc_pkg.sv
rtl/mdc_in_if.sv
rtl/mdc_out_if.sv
rtl/mdc_div.sv
rtl/matrix_double_centering.sv
rtl/mdc_chk.sv
sim/tb.sv
